[rtl/fxa_pkg.sv]
// package for the q24.8 fixed-point alu: operation codes, widths, pipeline payload types
// no dependencies
`timescale 1ns / 1ps

package fxa_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 4;
    localparam int FRAC_BITS = 8;
    // quotient bits produced by the division chain (the numerator 2*|a|<<f + |b| fits in 41 bits)
    localparam int QUO_W     = 63;

    localparam logic [MODE_W-1:0] OP_ADD  = 4'd0;
    localparam logic [MODE_W-1:0] OP_SUB  = 4'd1;
    localparam logic [MODE_W-1:0] OP_MUL  = 4'd2;
    localparam logic [MODE_W-1:0] OP_DIV  = 4'd3;
    localparam logic [MODE_W-1:0] OP_MIN  = 4'd4;
    localparam logic [MODE_W-1:0] OP_MAX  = 4'd5;
    localparam logic [MODE_W-1:0] OP_INC  = 4'd6;
    localparam logic [MODE_W-1:0] OP_DEC  = 4'd7;
    localparam logic [MODE_W-1:0] OP_TOI  = 4'd8;
    localparam logic [MODE_W-1:0] OP_FROMI = 4'd9;

    // operation state carried through the division cells
    typedef struct packed {
        logic                    neg;   // sign of the final result
        logic [QUO_W:0]          rem;   // partial remainder (2*num scale)
        logic [QUO_W-1:0]        quo;   // quotient bits so far
        logic [DATA_W:0]         den2;  // 2*|b|
        logic [QUO_W-1:0]        num;   // 2*|a|<<f + |b|, consumed msb first
    } t_div;

    // finished or pass-through result with flags
    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              less;
        logic              equal;
        logic              greater;
        logic              overflow;
        logic              div_zero;
    } t_res;

endpackage

[rtl/fxa_if.sv]
// valid/ready stream interface used by the alu channels
// depends on fxa_pkg
`timescale 1ns / 1ps

interface fxa_req_if;
    logic                                   valid;
    logic                                   ready;
    logic [fxa_pkg::MODE_W-1:0]             mode;
    logic signed [fxa_pkg::DATA_W-1:0]      operand_a;
    logic signed [fxa_pkg::DATA_W-1:0]      operand_b;
    modport source (output valid, mode, operand_a, operand_b, input ready);
    modport sink   (input valid, mode, operand_a, operand_b, output ready);
endinterface

interface fxa_rsp_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [fxa_pkg::DATA_W-1:0]      result;
    logic                                   less;
    logic                                   equal;
    logic                                   greater;
    logic                                   overflow;
    logic                                   divide_by_zero;
    modport source (output valid, result, less, equal, greater, overflow, divide_by_zero,
                    input ready);
    modport sink   (input valid, result, less, equal, greater, overflow, divide_by_zero,
                    output ready);
endinterface

[rtl/fixed_point_q24_8_alu.sv]
// q24.8 fixed-point alu top level: front stage, chain of division cells, output stage
// depends on fxa_pkg, fxa_if, fxa_cell
// stages: front, one per division cell, output; one request per cycle while the output is
// taken; the division quotient is built by a chain of 16 cells, 4 bits each; the whole
// pipe advances together and stalls only when the output register is full and not taken
// reset: synchronous active low, clears all valid bits; payload registers are not reset
`timescale 1ns / 1ps

module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fxa_pkg::FRAC_BITS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    fxa_req_if.sink    i_req,
    fxa_rsp_if.source  o_rsp
);

    localparam int W     = fxa_pkg::DATA_W;
    localparam int QW    = fxa_pkg::QUO_W;
    localparam int STEPS = 4;
    localparam int NUM_CELLS = (QW + STEPS - 1) / STEPS;
    localparam int PAD   = NUM_CELLS * STEPS - QW;

    logic en;
    // pipeline moves when the output slot is free or is being taken
    assign en = !o_rsp.valid || o_rsp.ready;
    assign i_req.ready = en;

    // ---------------- front stage: everything but the division ----------------
    logic signed [W:0]   sum_ab, dif_ab, inc_a, dec_a;
    logic [W-1:0]        mag_a, mag_b;
    logic [2*W-1:0]      prod;
    logic [2*W-1:0]      prod_rnd;
    logic                sgn_diff;
    logic                lt, eq, gt;
    fxa_pkg::t_res       n_res0;
    fxa_pkg::t_div       n_div0;
    logic                n_isdiv0;
    logic [W:0]          den2;
    logic [QW-1:0]       num_full;

    function automatic logic [W-1:0] sat_s(input logic signed [W:0] v, output logic ov);
        logic [W-1:0] r;
        ov = (v[W] != v[W-1]);
        if (ov) r = v[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
        else    r = v[W-1:0];
        return r;
    endfunction

    always_comb begin
        logic              ov;
        logic [2*W-1:0]    mag_neg_lim;
        logic signed [2*W-1:0] shl;
        logic [W-1:0]      rr;
        logic [W-1:0]      toi;

        sum_ab = $signed({i_req.operand_a[W-1], i_req.operand_a})
               + $signed({i_req.operand_b[W-1], i_req.operand_b});
        dif_ab = $signed({i_req.operand_a[W-1], i_req.operand_a})
               - $signed({i_req.operand_b[W-1], i_req.operand_b});
        inc_a  = $signed({i_req.operand_a[W-1], i_req.operand_a}) + (W+1)'(1);
        dec_a  = $signed({i_req.operand_a[W-1], i_req.operand_a}) - (W+1)'(1);
        mag_a  = i_req.operand_a[W-1] ? W'(-i_req.operand_a) : i_req.operand_a;
        mag_b  = i_req.operand_b[W-1] ? W'(-i_req.operand_b) : i_req.operand_b;
        sgn_diff = i_req.operand_a[W-1] ^ i_req.operand_b[W-1];
        prod   = mag_a * mag_b;
        prod_rnd = (prod + ((2*W)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
        lt = i_req.operand_a < i_req.operand_b;
        eq = i_req.operand_a == i_req.operand_b;
        gt = i_req.operand_a > i_req.operand_b;
        mag_neg_lim = {{W{1'b0}}, 1'b1, {(W-1){1'b0}}};
        shl = (2*W)'(i_req.operand_a) <<< FRAC_BITS;
        toi = W'(i_req.operand_a >>> FRAC_BITS);

        ov = 1'b0;
        rr = '0;
        case (i_req.mode)
            fxa_pkg::OP_ADD: rr = sat_s(sum_ab, ov);
            fxa_pkg::OP_SUB: rr = sat_s(dif_ab, ov);
            fxa_pkg::OP_MUL: begin
                if (sgn_diff) begin
                    ov = prod_rnd > mag_neg_lim;
                    rr = ov ? {1'b1, {(W-1){1'b0}}} : W'(-prod_rnd);
                end else begin
                    ov = prod_rnd > (mag_neg_lim - (2*W)'(1));
                    rr = ov ? {1'b0, {(W-1){1'b1}}} : prod_rnd[W-1:0];
                end
            end
            fxa_pkg::OP_MIN: rr = lt ? i_req.operand_a : i_req.operand_b;
            fxa_pkg::OP_MAX: rr = gt ? i_req.operand_a : i_req.operand_b;
            fxa_pkg::OP_INC: rr = sat_s(inc_a, ov);
            fxa_pkg::OP_DEC: rr = sat_s(dec_a, ov);
            fxa_pkg::OP_TOI: rr = toi;
            fxa_pkg::OP_FROMI: begin
                ov = (shl >>> FRAC_BITS) != (2*W)'(i_req.operand_a)
                     || (shl[2*W-1:W-1] != {(W+1){shl[W-1]}});
                if (ov) rr = i_req.operand_a[W-1] ? {1'b1, {(W-1){1'b0}}}
                                                  : {1'b0, {(W-1){1'b1}}};
                else    rr = shl[W-1:0];
            end
            default: rr = '0;
        endcase

        n_isdiv0 = (i_req.mode == fxa_pkg::OP_DIV) && (i_req.operand_b != '0);
        n_res0.result   = rr;
        n_res0.less     = lt;
        n_res0.equal    = eq;
        n_res0.greater  = gt;
        n_res0.overflow = ov;
        n_res0.div_zero = 1'b0;
        if (i_req.mode == fxa_pkg::OP_DIV) begin
            n_res0.overflow = 1'b0;
            n_res0.div_zero = (i_req.operand_b == '0);
            n_res0.result   = i_req.operand_a[W-1] ? {1'b1, {(W-1){1'b0}}}
                                                   : {1'b0, {(W-1){1'b1}}};
        end

        // q = (2*|a|<<f + |b|) / (2*|b|)
        den2     = {mag_b, 1'b0};
        num_full = (QW'(mag_a) << (FRAC_BITS + 1)) + QW'(mag_b);
        n_div0.neg  = sgn_diff;
        n_div0.rem  = '0;
        n_div0.quo  = '0;
        n_div0.den2 = den2;
        n_div0.num  = num_full;
    end

    logic               r_v0;
    logic               r_isdiv0;
    fxa_pkg::t_div      r_div0;
    fxa_pkg::t_res      r_res0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (en) begin
            r_v0 <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_isdiv0 <= n_isdiv0;
            r_div0   <= n_div0;
            r_res0   <= n_res0;
        end
    end

    // ---------------- division chain ----------------
    logic          c_v     [NUM_CELLS+1];
    logic          c_isdiv [NUM_CELLS+1];
    fxa_pkg::t_div c_div   [NUM_CELLS+1];
    fxa_pkg::t_res c_res   [NUM_CELLS+1];

    assign c_v[0]     = r_v0;
    assign c_isdiv[0] = r_isdiv0;
    assign c_div[0]   = r_div0;
    assign c_res[0]   = r_res0;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        fxa_cell #(.STEPS(STEPS)) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (en),
            .i_valid  (c_v[g]),
            .i_is_div (c_isdiv[g]),
            .i_div    (c_div[g]),
            .i_res    (c_res[g]),
            .o_valid  (c_v[g+1]),
            .o_is_div (c_isdiv[g+1]),
            .o_div    (c_div[g+1]),
            .o_res    (c_res[g+1])
        );
    end

    // ---------------- output stage: sign and saturate quotient ----------------
    fxa_pkg::t_res n_out;
    always_comb begin
        logic [QW-1:0] q;
        fxa_pkg::t_div d;
        d = c_div[NUM_CELLS];
        // extra steps past the last numerator bit shifted in zeros; drop them
        q = d.quo >> PAD;
        n_out = c_res[NUM_CELLS];
        if (c_isdiv[NUM_CELLS]) begin
            if (d.neg) begin
                n_out.overflow = q > QW'({1'b1, {(W-1){1'b0}}});
                n_out.result   = n_out.overflow ? {1'b1, {(W-1){1'b0}}} : W'(-q);
            end else begin
                n_out.overflow = q > QW'({1'b0, {(W-1){1'b1}}});
                n_out.result   = n_out.overflow ? {1'b0, {(W-1){1'b1}}} : q[W-1:0];
            end
        end
    end

    logic          r_out_v;
    fxa_pkg::t_res r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (en) begin
            r_out_v <= c_v[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out <= n_out;
        end
    end

    assign o_rsp.valid          = r_out_v;
    assign o_rsp.result         = r_out.result;
    assign o_rsp.less           = r_out.less;
    assign o_rsp.equal          = r_out.equal;
    assign o_rsp.greater        = r_out.greater;
    assign o_rsp.overflow       = r_out.overflow;
    assign o_rsp.divide_by_zero = r_out.div_zero;

endmodule

[rtl/fxa_cell.sv]
// one cell of the alu chain: STEPS restoring division steps plus a pass-along of the item
// depends on fxa_pkg
`timescale 1ns / 1ps

module fxa_cell #(
    parameter int STEPS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic             i_is_div,
    input  fxa_pkg::t_div    i_div,
    input  fxa_pkg::t_res    i_res,
    output logic             o_valid,
    output logic             o_is_div,
    output fxa_pkg::t_div    o_div,
    output fxa_pkg::t_res    o_res
);

    fxa_pkg::t_div n_div;
    fxa_pkg::t_div r_div;
    fxa_pkg::t_res r_res;
    logic          r_valid;
    logic          r_is_div;

    // restoring division steps, one quotient bit each
    always_comb begin
        logic [fxa_pkg::QUO_W:0] trial;
        n_div = i_div;
        for (int s = 0; s < STEPS; s++) begin
            trial = {n_div.rem[fxa_pkg::QUO_W-1:0], n_div.num[fxa_pkg::QUO_W-1]};
            n_div.num = {n_div.num[fxa_pkg::QUO_W-2:0], 1'b0};
            if (trial >= {{(fxa_pkg::QUO_W-fxa_pkg::DATA_W){1'b0}}, n_div.den2}) begin
                n_div.rem = trial - {{(fxa_pkg::QUO_W-fxa_pkg::DATA_W){1'b0}}, n_div.den2};
                n_div.quo = {n_div.quo[fxa_pkg::QUO_W-2:0], 1'b1};
            end else begin
                n_div.rem = trial;
                n_div.quo = {n_div.quo[fxa_pkg::QUO_W-2:0], 1'b0};
            end
        end
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_is_div <= i_is_div;
            r_div    <= n_div;
            r_res    <= i_res;
        end
    end

    assign o_valid  = r_valid;
    assign o_is_div = r_is_div;
    assign o_div    = r_div;
    assign o_res    = r_res;

endmodule

[rtl/fxa_checker.sv]
// port-level checks for the fixed-point alu, bound to the top level
// depends on the top level ports
`timescale 1ns / 1ps

module fxa_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input logic less,
    input logic equal,
    input logic greater,
    input logic overflow,
    input logic divide_by_zero
);

    // comparison flags are exclusive
    a_cmp_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> $onehot({less, equal, greater}))
        else $error("compare flags not one-hot");

    // saturation and divide-by-zero never both
    a_flag_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid |-> !(overflow && divide_by_zero))
        else $error("overflow with divide by zero");

    // input side accepts whenever output is free
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !rsp_valid |-> req_ready)
        else $error("stall with empty output");

    // stalled response holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped");

    // stalled request stays offered
    a_req_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && !req_ready |=> req_valid)
        else $error("request withdrawn while stalled");

endmodule

bind fixed_point_q24_8_alu fxa_checker u_fxa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .req_valid      (i_req.valid),
    .req_ready      (i_req.ready),
    .rsp_valid      (o_rsp.valid),
    .rsp_ready      (o_rsp.ready),
    .less           (o_rsp.less),
    .equal          (o_rsp.equal),
    .greater        (o_rsp.greater),
    .overflow       (o_rsp.overflow),
    .divide_by_zero (o_rsp.divide_by_zero)
);

[test/testbench.sv]
// self-checking testbench for the q24.8 fixed-point alu: directed and random requests
// depends on fxa_pkg, fxa_if and the fixed_point_q24_8_alu top level
`timescale 1ns / 1ps

module testbench;
    import fxa_pkg::*;

    localparam int N_RANDOM  = 800;
    localparam int LIMIT_CYC = 200000;

    typedef struct packed {
        logic [DATA_W-1:0] result;
        logic              less;
        logic              equal;
        logic              greater;
        logic              overflow;
        logic              div_zero;
    } alu_out_t;

    // exact arithmetic prediction of one alu operation
    function automatic alu_out_t alu_predict(logic [MODE_W-1:0] op,
                                             logic signed [31:0] a,
                                             logic signed [31:0] b);
        alu_out_t o;
        logic signed [65:0] wide;
        logic [63:0] ma, mb, prod, q, num, den;
        logic neg;
        logic mag_path;
        o = '0;
        wide = 0;
        q = 0;
        mag_path = 1'b0;
        neg = (a < 0) != (b < 0);
        ma = (a < 0) ? 64'(-64'(signed'(a))) : 64'(a);
        mb = (b < 0) ? 64'(-64'(signed'(b))) : 64'(b);
        case (op)
            OP_ADD:   wide = 66'(a) + 66'(b);
            OP_SUB:   wide = 66'(a) - 66'(b);
            OP_MUL: begin
                prod = ma * mb;
                q = (prod + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
                mag_path = 1'b1;
            end
            OP_DIV: begin
                if (b == 0) begin
                    o.div_zero = 1'b1;
                    wide = (a < 0) ? -66'sd2147483648 : 66'sd2147483647;
                end else begin
                    num = ma << FRAC_BITS;
                    den = mb;
                    q = (2 * num + den) / (2 * den);
                    mag_path = 1'b1;
                end
            end
            OP_MIN:   wide = (a < b) ? 66'(a) : 66'(b);
            OP_MAX:   wide = (a > b) ? 66'(a) : 66'(b);
            OP_INC:   wide = 66'(a) + 1;
            OP_DEC:   wide = 66'(a) - 1;
            OP_TOI:   wide = 66'(a) >>> FRAC_BITS;
            OP_FROMI: wide = 66'(a) <<< FRAC_BITS;
            default:  wide = 0;
        endcase
        if (mag_path) begin
            if (neg) begin
                if (q > 64'h8000_0000) begin
                    o.overflow = 1'b1;
                    wide = -66'sd2147483648;
                end else wide = -$signed({2'b00, q});
            end else begin
                if (q > 64'h7fff_ffff) begin
                    o.overflow = 1'b1;
                    wide = 66'sd2147483647;
                end else wide = $signed({2'b00, q});
            end
        end else if (wide > 66'sd2147483647) begin
            o.overflow = 1'b1;
            wide = 66'sd2147483647;
        end else if (wide < -66'sd2147483648) begin
            o.overflow = 1'b1;
            wide = -66'sd2147483648;
        end
        o.result  = wide[31:0];
        o.less    = a < b;
        o.equal   = a == b;
        o.greater = a > b;
        return o;
    endfunction

    // pending expected results in request order
    class alu_scoreboard;
        alu_out_t pending[$];
        int       errors;
        int       checked;

        function void note_request(logic [MODE_W-1:0] op, logic [31:0] a, logic [31:0] b);
            pending.push_back(alu_predict(op, a, b));
        endfunction

        function void check_result(alu_out_t got);
            alu_out_t exp;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            checked++;
            if (got !== exp) begin
                $display("%0t: mismatch expected res=%h l%b e%b g%b ov%b dz%b", $time,
                         exp.result, exp.less, exp.equal, exp.greater, exp.overflow,
                         exp.div_zero);
                $display("%0t:          actual   res=%h l%b e%b g%b ov%b dz%b", $time,
                         got.result, got.less, got.equal, got.greater, got.overflow,
                         got.div_zero);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    int   cycle_cnt;
    bit   calm;
    bit   stim_done;
    alu_scoreboard sb;

    fxa_req_if req_if ();
    fxa_rsp_if rsp_if ();

    fixed_point_q24_8_alu dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_rsp   (rsp_if.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > LIMIT_CYC) begin
            $display("fixed_point_q24_8_alu test failed");
            $finish;
        end
    end

    // response side: sample at rising edge, stall at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result({rsp_if.result, rsp_if.less, rsp_if.equal, rsp_if.greater,
                             rsp_if.overflow, rsp_if.divide_by_zero});
    end

    always @(negedge i_clk)
        rsp_if.ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);

    // drive one request, hold until accepted
    task automatic send_request(logic [MODE_W-1:0] op, logic [31:0] a, logic [31:0] b);
        while (!calm && $urandom_range(99) < 12) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.mode      <= op;
        req_if.operand_a <= a;
        req_if.operand_b <= b;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
        sb.note_request(op, a, b);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_operand();
        case ($urandom_range(7))
            0:       return 32'h8000_0000 + $urandom_range(3);
            1:       return 32'h7fff_ffff - $urandom_range(3);
            2:       return $urandom_range(4) - 2;
            3:       return 32'($signed($urandom_range(8000)) - 4000);
            4:       return $urandom_range(255) << $urandom_range(23);
            5:       return -($urandom_range(65535) << 8);
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] a, b;
        logic [MODE_W-1:0] op;
        sb = new();
        cycle_cnt = 0;
        calm = 1'b0;
        stim_done = 1'b0;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode = '0;
        req_if.operand_a = '0;
        req_if.operand_b = '0;
        rsp_if.ready = 1'b0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: each mode, most at the range extremes, divide by zero, unused codes
        send_request(OP_ADD, 32'h7fff_ffff, 32'h1);
        send_request(OP_ADD, 32'h8000_0000, 32'hffff_ffff);
        send_request(OP_SUB, 32'h8000_0000, 32'h1);
        send_request(OP_SUB, 32'h7fff_ffff, 32'h8000_0000);
        send_request(OP_MUL, 32'h8000_0000, 32'h8000_0000);
        send_request(OP_MUL, 32'h0000_0180, 32'hffff_ff80);
        send_request(OP_MUL, 32'h0000_0001, 32'h0000_0080);
        send_request(OP_DIV, 32'h0000_0100, 32'h0);
        send_request(OP_DIV, 32'h8000_0000, 32'h0);
        send_request(OP_DIV, 32'h8000_0000, 32'h0000_0001);
        send_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff);
        send_request(OP_DIV, 32'h0000_0001, 32'h0000_0200);
        send_request(OP_MIN, 32'h5, 32'h5);
        send_request(OP_MAX, 32'h8000_0000, 32'h7fff_ffff);
        send_request(OP_INC, 32'h7fff_ffff, 32'h0);
        send_request(OP_DEC, 32'h8000_0000, 32'h0);
        send_request(OP_TOI, 32'h8000_0000, 32'h0);
        send_request(OP_TOI, 32'hffff_ff01, 32'h0);
        send_request(OP_FROMI, 32'h0080_0000, 32'h0);
        send_request(OP_FROMI, 32'hff7f_ffff, 32'h0);
        send_request(4'd10, 32'h1, 32'h2);
        send_request(4'd15, 32'hffff_ffff, 32'hffff_ffff);

        // random: middle stretch runs without stalls
        for (int i = 0; i < N_RANDOM; i++) begin
            calm = (i >= 300 && i < 450);
            op = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 10))
                                           : 4'($urandom_range(9));
            a = pick_operand();
            b = ($urandom_range(15) == 0) ? 32'h0 : pick_operand();
            if ($urandom_range(9) == 0) b = a;
            send_request(op, a, b);
        end
        req_if.valid <= 1'b0;
        calm = 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        $display("covered %0d checked results over all ten operations and unused codes",
                 sb.checked);
        if (sb.errors == 0)
            $display("fixed_point_q24_8_alu test passed");
        else
            $display("fixed_point_q24_8_alu test failed");
        $finish;
    end
endmodule
